>>> src/dos_pkg.sv
`default_nettype none
package dos_pkg;

  localparam int unsigned OPTIONS_BYTES = 312;
  localparam int unsigned POS_W = 10;
  localparam logic [POS_W-1:0] POS_MAX = '1;
  localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(OPTIONS_BYTES);
  localparam logic [POS_W-1:0] POS_COOKIE_LAST = POS_W'(3);
  localparam logic [POS_W-1:0] POS_COOKIE_DONE = POS_W'(4);

  localparam logic [7:0] OPT_PAD = 8'd0;
  localparam logic [7:0] OPT_END = 8'd255;
  localparam logic [7:0] OPT_MSG_TYPE = 8'd53;
  localparam logic [7:0] OPT_SERVER_ID = 8'd54;
  localparam logic [7:0] LEN_MSG_TYPE = 8'd1;
  localparam logic [7:0] LEN_SERVER_ID = 8'd4;

  localparam int unsigned OUT_TDATA_W = 48;

  typedef enum logic [2:0] {
    PH_COOKIE = 3'd0,
    PH_CODE   = 3'd1,
    PH_LEN    = 3'd2,
    PH_VALUE  = 3'd3,
    PH_DONE   = 3'd4
  } phase_t;

  typedef struct packed {
    logic        cookie_valid;
    logic [7:0]  message_type;
    logic        srv_ident_found;
    logic [31:0] srv_ident;
  } result_t;

  // Magic cookie 0x63825363, first byte on the wire at index 0
  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = 8'h63;
      2'd1:    b = 8'h82;
      2'd2:    b = 8'h53;
      2'd3:    b = 8'h63;
      default: b = 8'h63;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

>>> src/dos_scan.sv
`default_nettype none
module dos_scan
  import dos_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step,
  input  wire logic [7:0] data_byte,
  input  wire logic       last_byte,
  output result_t         result
);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             cm_r, cm_nxt;
  phase_t           phase_r, phase_nxt;
  logic [7:0]       code_r, code_nxt;
  logic [7:0]       rem_r, rem_nxt;
  logic [31:0]      vc_r, vc_nxt;
  logic [7:0]       tval_r, tval_nxt;
  logic             tfound_r, tfound_nxt;
  logic [31:0]      sval_r, sval_nxt;
  logic             sfound_r, sfound_nxt;
  logic             take;
  logic             cookie_ok;

  assign take = (pos_r < POS_LIMIT);

  // Next state: one option byte
  always_comb begin
    pos_nxt    = (pos_r != POS_MAX) ? pos_r + POS_W'(1) : pos_r;
    cm_nxt     = cm_r;
    phase_nxt  = phase_r;
    code_nxt   = code_r;
    rem_nxt    = rem_r;
    vc_nxt     = vc_r;
    tval_nxt   = tval_r;
    tfound_nxt = tfound_r;
    sval_nxt   = sval_r;
    sfound_nxt = sfound_r;
    if (take) begin
      case (phase_r)
        PH_COOKIE: begin
          if (data_byte != magic_byte(pos_r[1:0])) cm_nxt = 1'b0;
          if (pos_r == POS_COOKIE_LAST) phase_nxt = cm_nxt ? PH_CODE : PH_DONE;
        end
        PH_CODE: begin
          if (data_byte == OPT_END) begin
            phase_nxt = PH_DONE;
          end else if (data_byte != OPT_PAD) begin
            code_nxt  = data_byte;
            phase_nxt = PH_LEN;
          end
        end
        PH_LEN: begin
          if (!((code_r == OPT_MSG_TYPE && data_byte == LEN_MSG_TYPE) ||
                (code_r == OPT_SERVER_ID && data_byte == LEN_SERVER_ID))) begin
            code_nxt = OPT_PAD;
          end
          rem_nxt   = data_byte;
          vc_nxt    = '0;
          phase_nxt = (data_byte == 8'd0) ? PH_CODE : PH_VALUE;
        end
        PH_VALUE: begin
          vc_nxt  = {vc_r[23:0], data_byte};
          rem_nxt = rem_r - 8'd1;
          if (rem_nxt == 8'd0) begin
            // Close the option; capture only the first qualifying one
            if (code_r == OPT_MSG_TYPE && !tfound_r) begin
              tval_nxt   = vc_nxt[7:0];
              tfound_nxt = 1'b1;
            end else if (code_r == OPT_SERVER_ID && !sfound_r) begin
              sval_nxt   = vc_nxt;
              sfound_nxt = 1'b1;
            end
            phase_nxt = PH_CODE;
          end
        end
        default: ;
      endcase
    end
  end

  // Result as seen after this byte
  always_comb begin
    cookie_ok              = (pos_nxt >= POS_COOKIE_DONE) && cm_nxt;
    result.cookie_valid    = cookie_ok;
    result.message_type    = (cookie_ok && tfound_nxt) ? tval_nxt : 8'd0;
    result.srv_ident_found = cookie_ok && sfound_nxt;
    result.srv_ident       = (cookie_ok && sfound_nxt) ? sval_nxt : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && last_byte)) begin
      pos_r    <= '0;
      cm_r     <= 1'b1;
      phase_r  <= PH_COOKIE;
      code_r   <= '0;
      rem_r    <= '0;
      vc_r     <= '0;
      tval_r   <= '0;
      tfound_r <= 1'b0;
      sval_r   <= '0;
      sfound_r <= 1'b0;
    end else if (step) begin
      pos_r    <= pos_nxt;
      cm_r     <= cm_nxt;
      phase_r  <= phase_nxt;
      code_r   <= code_nxt;
      rem_r    <= rem_nxt;
      vc_r     <= vc_nxt;
      tval_r   <= tval_nxt;
      tfound_r <= tfound_nxt;
      sval_r   <= sval_nxt;
      sfound_r <= sfound_nxt;
    end
  end

endmodule
`default_nettype wire

>>> src/dhcp_option_scanner_top.sv
`default_nettype none
// DHCP options scanner. Feed the options field one byte per transaction,
// starting with the four-byte magic cookie, and mark the final byte with
// in_tlast. Exactly one result transaction follows each field: the cookie
// check, the first length-1 message-type option (53) and the first length-4
// server-identifier option (54); fields are zero when the cookie is bad or
// the option was not found, and an option cut off by the end of the field is
// ignored. Only the first 312 bytes of a field are parsed. The block
// takes one byte every clock unless stalled: an input register holds the
// byte, the option walker then updates its state and, on the last byte,
// loads the result register. Input stalls only while a final byte waits
// for a result register that is still full and not being taken. The
// scanner returns to its reset state after each field, ready for the next
// one.
module dhcp_option_scanner_top
  import dos_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output      logic                   in_tready,
  input  wire logic [7:0]             in_tdata,   // [7:0] data_byte
  input  wire logic                   in_tlast,   // last_byte
  output      logic                   out_tvalid,
  input  wire logic                   out_tready,
  // [0] cookie_valid, [8:1] message_type, [9] srv_ident_found,
  // [41:10] srv_ident, [47:42] zero
  output      logic [OUT_TDATA_W-1:0] out_tdata
);

  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;
  logic       out_valid_r;
  result_t    out_res_r;
  result_t    scan_res;
  logic       out_free;
  logic       advance;
  logic       in_fire;

  // Result slot is free if empty or being drained this cycle
  assign out_free  = !out_valid_r || out_tready;
  // Advance the held byte unless it is a final byte with no room for its result
  assign advance   = in_valid_r && (!in_last_r || out_free);
  assign in_tready = !in_valid_r || advance;
  assign in_fire   = in_tvalid && in_tready;

  dos_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .data_byte (in_byte_r),
    .last_byte (in_last_r),
    .result    (scan_res)
  );

  // Input register: hold the byte until the walker takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  // Result register: load on the final byte, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && in_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last_r) begin
      out_res_r <= scan_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_res_r.srv_ident, out_res_r.srv_ident_found,
                       out_res_r.message_type, out_res_r.cookie_valid};

`ifndef ASSERT_OFF
  // A bad or short cookie reports nothing else
  a_bad_cookie_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[41:1] == 41'd0)
    else $error("result fields set with an invalid cookie");

  // Server id is zero unless it was found
  a_sid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[9] |-> out_tdata[41:10] == 32'd0)
    else $error("server id set without found flag");

  // A final byte may only be held back while the result slot is occupied
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !advance |-> in_last_r && out_valid_r && !out_tready)
    else $error("byte stalled without a full result register");

  // A result is loaded only when the previous one has gone or is going
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    advance && in_last_r |-> !out_valid_r || out_tready)
    else $error("result register overwritten");
`endif

endmodule
`default_nettype wire
